### sv/slt_pkg.sv
package slt_pkg;

   localparam int STATION_W = 4;
   localparam int SAMPLE_W  = 32;
   localparam int AVG_W     = 48;
   localparam int GAIN_W    = 16;
   localparam int COUNT_W   = 16;
   localparam int PROD_W    = 64;
   // wide enough to compare a station number against a station count up to 511
   localparam int SEL_W     = 9;
   localparam int CSR_IDX_W = 2;
   localparam int STEP_W    = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_GAIN      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_GAIN       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_THRESHOLD = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH   = 2'd3;

   localparam logic [GAIN_W-1:0]  SHORT_GAIN_RESET      = 16'd6554;
   localparam logic [GAIN_W-1:0]  LONG_GAIN_RESET       = 16'd655;
   localparam logic [GAIN_W-1:0]  RATIO_THRESHOLD_RESET = 16'd1280;
   localparam logic [COUNT_W-1:0] WINDOW_LENGTH_RESET   = 16'd1000;

   localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
   localparam logic [STEP_W-1:0] STEP_LOAD   = 3'd1;
   localparam logic [STEP_W-1:0] STEP_MUL_S  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_UPD_S  = 3'd3;
   localparam logic [STEP_W-1:0] STEP_UPD_L  = 3'd4;
   localparam logic [STEP_W-1:0] STEP_MUL_T  = 3'd5;
   localparam logic [STEP_W-1:0] STEP_FINISH = 3'd6;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_WAIT_REQ,
      JMP_WAIT_RSP,
      JMP_GOTO
   } slt_jump_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_SHORT,
      MUL_LONG,
      MUL_THRESH
   } slt_mul_type;

   typedef enum logic [1:0] {
      UPD_NONE,
      UPD_SHORT,
      UPD_LONG
   } slt_upd_type;

   typedef struct packed {
      slt_jump_type      jump;
      logic [STEP_W-1:0] target;
      logic              accept;
      logic              load;
      slt_mul_type       mul_sel;
      slt_upd_type       upd_sel;
      logic              count;
      logic              finish;
   } slt_ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic rsp_free;
   } slt_cond_type;

   localparam slt_ctrl_type CTRL_NOP = '{
      jump:    JMP_NEXT,
      target:  STEP_IDLE,
      accept:  1'b0,
      load:    1'b0,
      mul_sel: MUL_NONE,
      upd_sel: UPD_NONE,
      count:   1'b0,
      finish:  1'b0
   };

   // microprogram: one control word per step
   function automatic slt_ctrl_type slt_ucode(input logic [STEP_W-1:0] step);
      slt_ctrl_type c;
      c = CTRL_NOP;
      unique case (step)
         STEP_IDLE: begin
            c.jump   = JMP_WAIT_REQ;
            c.accept = 1'b1;
         end
         STEP_LOAD: begin
            c.load = 1'b1;
         end
         STEP_MUL_S: begin
            c.mul_sel = MUL_SHORT;
         end
         STEP_UPD_S: begin
            c.upd_sel = UPD_SHORT;
            c.mul_sel = MUL_LONG;
         end
         STEP_UPD_L: begin
            c.upd_sel = UPD_LONG;
         end
         STEP_MUL_T: begin
            c.mul_sel = MUL_THRESH;
            c.count   = 1'b1;
         end
         STEP_FINISH: begin
            c.jump   = JMP_WAIT_RSP;
            c.target = STEP_IDLE;
            c.finish = 1'b1;
         end
         default: begin
            c.jump   = JMP_GOTO;
            c.target = STEP_IDLE;
         end
      endcase
      return c;
   endfunction

endpackage

### sv/slt_seq.sv
module slt_seq
   import slt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  slt_cond_type cond,
   output slt_ctrl_type ctrl
);

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      ctrl = slt_ucode(step_ff);
      unique case (ctrl.jump)
         JMP_NEXT:     step_in = step_ff + 3'd1;
         JMP_WAIT_REQ: step_in = cond.req_valid ? step_ff + 3'd1 : step_ff;
         JMP_WAIT_RSP: step_in = cond.rsp_free ? ctrl.target : step_ff;
         JMP_GOTO:     step_in = ctrl.target;
         default:      step_in = STEP_IDLE;
      endcase
   end

endmodule

### sv/sta_lta_event_trigger.sv
// An accepted req beat runs the load, short multiply, short update, long update,
// threshold multiply and finish steps, and the next sample waits for idle; the
// single shared 48x16 multiplier serves the two average steps and the ratio test.
// A waiting rsp beat does not block the next sample until its finish step.
// Reset (synchronous): restores the register defaults, clears the sequencer
// and the per-station valid bits, so every station reads as zero state.
module sta_lta_event_trigger
   import slt_pkg::*;
#(
   parameter int STATIONS = 16
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [STATION_W-1:0] req_station,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                 req_packet_end,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATION_W-1:0] rsp_station_out,
   output logic [AVG_W-1:0]     rsp_short_avg,
   output logic [AVG_W-1:0]     rsp_long_avg,
   output logic                 rsp_window_full,
   output logic                 rsp_trigger,
   output logic                 rsp_packet_end_out,

   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]    csr_wdata
);

   localparam int IDX_W = (STATIONS > 1) ? $clog2(STATIONS) : 1;

   typedef struct packed {
      logic [AVG_W-1:0]   sta;
      logic [AVG_W-1:0]   lta;
      logic [COUNT_W-1:0] cnt;
   } slt_entry_type;

   // configuration
   logic [GAIN_W-1:0]  short_gain_ff;
   logic [GAIN_W-1:0]  long_gain_ff;
   logic [GAIN_W-1:0]  threshold_ff;
   logic [COUNT_W-1:0] window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_gain_ff <= SHORT_GAIN_RESET;
         long_gain_ff  <= LONG_GAIN_RESET;
         threshold_ff  <= RATIO_THRESHOLD_RESET;
         window_ff     <= WINDOW_LENGTH_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SHORT_GAIN:      short_gain_ff <= csr_wdata;
            CSR_LONG_GAIN:       long_gain_ff  <= csr_wdata;
            CSR_RATIO_THRESHOLD: threshold_ff  <= csr_wdata;
            CSR_WINDOW_LENGTH:   window_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   slt_ctrl_type ctrl;
   slt_cond_type cond;
   logic         rsp_valid_ff;
   logic         rsp_free;
   logic         req_beat;
   logic         fin_fire;

   assign rsp_free       = !rsp_valid_ff || !rsp_stall;
   assign cond.req_valid = req_valid;
   assign cond.rsp_free  = rsp_free;

   slt_seq u_seq (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctrl  (ctrl)
   );

   assign req_stall = !ctrl.accept;
   assign req_beat  = req_valid && ctrl.accept;
   assign fin_fire  = ctrl.finish && rsp_free;

   // input capture
   logic [SEL_W-1:0]    req_sel;
   logic [SAMPLE_W-1:0] samp_u;
   logic [SAMPLE_W-1:0] mag_in;

   logic [STATION_W-1:0] station_ff;
   logic                 pend_ff;
   logic                 range_ff;
   logic [SAMPLE_W-1:0]  mag_ff;

   assign req_sel = {{(SEL_W-STATION_W){1'b0}}, req_station};
   assign samp_u  = req_sample;
   assign mag_in  = samp_u[SAMPLE_W-1] ? (~samp_u + 32'd1) : samp_u;

   always_ff @(posedge clock) begin
      if (req_beat) begin
         station_ff <= req_station;
         pend_ff    <= req_packet_end;
         range_ff   <= req_sel < SEL_W'(STATIONS);
         mag_ff     <= mag_in;
      end
   end

   // per-station store: one read and one write port, read data registered
   slt_entry_type        store_mem [STATIONS];
   logic [STATIONS-1:0]  valid_ff;
   slt_entry_type        rd_ff;
   logic                 rd_valid_ff;
   logic [IDX_W-1:0]     rd_idx;
   logic [IDX_W-1:0]     wr_idx;
   logic [SEL_W-1:0]     wr_sel;
   slt_entry_type        wr_data;
   logic                 wr_en;

   assign rd_idx = req_sel[IDX_W-1:0];
   assign wr_sel = {{(SEL_W-STATION_W){1'b0}}, station_ff};
   assign wr_idx = wr_sel[IDX_W-1:0];
   assign wr_en  = fin_fire && range_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_idx] <= wr_data;
      end
      if (req_beat) begin
         rd_ff <= store_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (req_beat) begin
            rd_valid_ff <= valid_ff[rd_idx];
         end
      end
   end

   // datapath
   logic [AVG_W-1:0]   sta_ff;
   logic [AVG_W-1:0]   lta_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic               full_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic               dir_ff;

   logic [AVG_W-1:0]   mag48;
   logic [AVG_W-1:0]   avg_sel;
   logic               dir_in;
   logic [AVG_W-1:0]   absdiff;
   logic [AVG_W-1:0]   mul_a;
   logic [GAIN_W-1:0]  mul_b;
   logic [PROD_W-1:0]  prod_in;
   logic [AVG_W-1:0]   avg_step;
   logic [AVG_W-1:0]   upd_base;
   logic [AVG_W-1:0]   upd_val;
   logic [COUNT_W-1:0] cnt_in;
   logic               trig_in;

   assign mag48    = {mag_ff, 16'b0};
   assign avg_sel  = (ctrl.mul_sel == MUL_LONG) ? lta_ff : sta_ff;
   assign dir_in   = mag48 >= avg_sel;
   assign absdiff  = dir_in ? (mag48 - avg_sel) : (avg_sel - mag48);
   assign mul_a    = (ctrl.mul_sel == MUL_THRESH) ? lta_ff : absdiff;

   always_comb begin
      unique case (ctrl.mul_sel)
         MUL_SHORT:  mul_b = short_gain_ff;
         MUL_LONG:   mul_b = long_gain_ff;
         MUL_THRESH: mul_b = threshold_ff;
         default:    mul_b = '0;
      endcase
   end

   assign prod_in  = PROD_W'(mul_a) * PROD_W'(mul_b);
   // truncate the step toward the old average
   assign avg_step = prod_ff[PROD_W-1:16];
   assign upd_base = (ctrl.upd_sel == UPD_LONG) ? lta_ff : sta_ff;
   assign upd_val  = dir_ff ? (upd_base + avg_step) : (upd_base - avg_step);
   assign cnt_in   = (cnt_ff != 16'hFFFF) ? (cnt_ff + 16'd1) : cnt_ff;
   // sta * 256 against threshold * lta, exact
   assign trig_in  = full_ff && (lta_ff != '0) && ({8'b0, sta_ff, 8'b0} > prod_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         sta_ff <= rd_valid_ff ? rd_ff.sta : '0;
         lta_ff <= rd_valid_ff ? rd_ff.lta : '0;
         cnt_ff <= rd_valid_ff ? rd_ff.cnt : '0;
      end else begin
         if (ctrl.upd_sel == UPD_SHORT) begin
            sta_ff <= upd_val;
         end
         if (ctrl.upd_sel == UPD_LONG) begin
            lta_ff <= upd_val;
         end
         if (ctrl.count) begin
            cnt_ff  <= cnt_in;
            full_ff <= cnt_in >= window_ff;
         end
      end
      if (ctrl.mul_sel != MUL_NONE) begin
         prod_ff <= prod_in;
         dir_ff  <= dir_in;
      end
   end

   assign wr_data.sta = sta_ff;
   assign wr_data.lta = lta_ff;
   assign wr_data.cnt = cnt_ff;

   // result register
   logic [STATION_W-1:0] rsp_station_ff;
   logic [AVG_W-1:0]     rsp_short_ff;
   logic [AVG_W-1:0]     rsp_long_ff;
   logic                 rsp_full_ff;
   logic                 rsp_trig_ff;
   logic                 rsp_pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_fire) begin
         rsp_station_ff <= station_ff;
         rsp_pend_ff    <= pend_ff;
         rsp_short_ff   <= range_ff ? sta_ff : '0;
         rsp_long_ff    <= range_ff ? lta_ff : '0;
         rsp_full_ff    <= range_ff && full_ff;
         rsp_trig_ff    <= range_ff && trig_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_station_out    = rsp_station_ff;
   assign rsp_short_avg      = rsp_short_ff;
   assign rsp_long_avg       = rsp_long_ff;
   assign rsp_window_full    = rsp_full_ff;
   assign rsp_trigger        = rsp_trig_ff;
   assign rsp_packet_end_out = rsp_pend_ff;

`ifndef ASSERT_OFF
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> req_stall)
      else $error("second sample taken while one is in flight");

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      fin_fire |=> rsp_valid)
      else $error("finished sample not offered");

   a_rise_after_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fin_fire))
      else $error("rsp beat appeared without a finish step");

   a_trig_needs_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_trigger || rsp_window_full))
      else $error("trigger without a full window");

   a_short_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_short_avg[AVG_W-1] || rsp_short_avg[AVG_W-2:0] == '0))
      else $error("short average above the largest magnitude");
`endif

endmodule

### sim/sta_lta_checker.sv
module sta_lta_checker
   import slt_pkg::*;
#(
   parameter int STATIONS = 16
) (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [STATION_W-1:0]       req_station,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_packet_end,

   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [STATION_W-1:0]       rsp_station_out,
   input  logic [AVG_W-1:0]           rsp_short_avg,
   input  logic [AVG_W-1:0]           rsp_long_avg,
   input  logic                       rsp_window_full,
   input  logic                       rsp_trigger,
   input  logic                       rsp_packet_end_out,

   input  logic                       csr_write,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [GAIN_W-1:0]          csr_wdata,

   output int                         fail_count,
   output int                         samples_waiting,
   output int                         beats_checked,
   output int                         triggers_seen
);

   typedef struct packed {
      logic [STATION_W-1:0] station;
      logic [AVG_W-1:0]     short_avg;
      logic [AVG_W-1:0]     long_avg;
      logic                 window_full;
      logic                 trigger;
      logic                 packet_end;
   } outcome_type;

   logic [GAIN_W-1:0]  short_gain;
   logic [GAIN_W-1:0]  long_gain;
   logic [GAIN_W-1:0]  ratio_thr;
   logic [COUNT_W-1:0] window_len;

   logic [AVG_W-1:0]   short_lvl [STATIONS];
   logic [AVG_W-1:0]   long_lvl  [STATIONS];
   logic [COUNT_W-1:0] seen_count[STATIONS];

   outcome_type station_outcomes[$];
   outcome_type want, got;
   int          errors;
   int          checked;
   int          trig_count;

   // step is truncated, so the average only ever moves towards the magnitude
   function automatic logic [AVG_W-1:0] ewma(input logic [AVG_W-1:0] avg,
                                             input logic [AVG_W-1:0] mag,
                                             input logic [GAIN_W-1:0] gain);
      logic [PROD_W-1:0] prod;
      if (mag >= avg) begin
         prod = PROD_W'(mag - avg) * PROD_W'(gain);
         return avg + prod[PROD_W-1:16];
      end
      prod = PROD_W'(avg - mag) * PROD_W'(gain);
      return avg - prod[PROD_W-1:16];
   endfunction

   function automatic outcome_type advance_station(input logic [STATION_W-1:0] st,
                                                   input logic [SAMPLE_W-1:0] smp,
                                                   input logic pend);
      outcome_type       o;
      logic [32:0]       abs_val;
      logic [AVG_W-1:0]  mag;
      logic [PROD_W-1:0] scaled_sta;
      logic [PROD_W-1:0] scaled_lta;
      o            = '0;
      o.station    = st;
      o.packet_end = pend;
      if (int'(st) < STATIONS) begin
         abs_val = smp[SAMPLE_W-1] ? 33'h1_0000_0000 - {1'b0, smp} : {1'b0, smp};
         mag     = {abs_val[31:0], 16'h0000};
         short_lvl[st] = ewma(short_lvl[st], mag, short_gain);
         long_lvl[st]  = ewma(long_lvl[st], mag, long_gain);
         if (seen_count[st] != '1) begin
            seen_count[st] = seen_count[st] + 1'b1;
         end
         o.short_avg   = short_lvl[st];
         o.long_avg    = long_lvl[st];
         o.window_full = (seen_count[st] >= window_len);
         scaled_sta    = {8'h00, short_lvl[st], 8'h00};
         scaled_lta    = PROD_W'(ratio_thr) * PROD_W'(long_lvl[st]);
         o.trigger     = o.window_full && (long_lvl[st] != '0) && (scaled_sta > scaled_lta);
      end
      return o;
   endfunction

   function automatic int field_differs(input string name, input logic [63:0] exp_val,
                                        input logic [63:0] act_val);
      if (exp_val === act_val) begin
         return 0;
      end
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_val, act_val);
      return 1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         short_gain = SHORT_GAIN_RESET;
         long_gain  = LONG_GAIN_RESET;
         ratio_thr  = RATIO_THRESHOLD_RESET;
         window_len = WINDOW_LENGTH_RESET;
         for (int i = 0; i < STATIONS; i++) begin
            short_lvl[i]  = '0;
            long_lvl[i]   = '0;
            seen_count[i] = '0;
         end
         station_outcomes.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_SHORT_GAIN:      short_gain = csr_wdata;
               CSR_LONG_GAIN:       long_gain  = csr_wdata;
               CSR_RATIO_THRESHOLD: ratio_thr  = csr_wdata;
               CSR_WINDOW_LENGTH:   window_len = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            station_outcomes.insert(station_outcomes.size(),
                                    advance_station(req_station, req_sample,
                                                    req_packet_end));
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_station_out, rsp_short_avg, rsp_long_avg, rsp_window_full,
                    rsp_trigger, rsp_packet_end_out};
            checked++;
            if (got.trigger) begin
               trig_count++;
            end
            if (station_outcomes.size() == 0) begin
               $display("%0t: rsp beat with no sample outstanding, expected none, got 0x%0h",
                        $time, got);
               errors++;
            end else begin
               want = station_outcomes[0];
               station_outcomes.delete(0);
               if (field_differs("station_out", 64'(want.station), 64'(got.station)) +
                   field_differs("short_avg", 64'(want.short_avg), 64'(got.short_avg)) +
                   field_differs("long_avg", 64'(want.long_avg), 64'(got.long_avg)) +
                   field_differs("window_full", 64'(want.window_full),
                                 64'(got.window_full)) +
                   field_differs("trigger", 64'(want.trigger), 64'(got.trigger)) +
                   field_differs("packet_end_out", 64'(want.packet_end),
                                 64'(got.packet_end)) != 0) begin
                  errors++;
               end
            end
         end
      end
      // publish after the edge so the top never races the update
      fail_count      <= errors;
      samples_waiting <= station_outcomes.size();
      beats_checked   <= checked;
      triggers_seen   <= trig_count;
   end

   initial begin
      errors     = 0;
      checked    = 0;
      trig_count = 0;
   end

endmodule

### sim/tb_top.sv
module tb_top
   import slt_pkg::*;
();

   localparam int LIMIT_CYCLES = 2_000_000;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES  = 400;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [STATION_W-1:0]       req_station;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       req_packet_end;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [STATION_W-1:0]       rsp_station_out;
   logic [AVG_W-1:0]           rsp_short_avg;
   logic [AVG_W-1:0]           rsp_long_avg;
   logic                       rsp_window_full;
   logic                       rsp_trigger;
   logic                       rsp_packet_end_out;
   logic                       csr_write;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [GAIN_W-1:0]          csr_wdata;

   int fail_count;
   int samples_waiting;
   int beats_checked;
   int triggers_seen;

   int req_idle_pct;
   int rsp_idle_pct;
   bit want_hold;
   bit hold_done;
   int hold_left;
   int cycles;

   sta_lta_event_trigger i_dut (.*);

   sta_lta_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d samples outstanding", cycles, samples_waiting);
      $display("simulation failed");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_stall <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (want_hold && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
         end
      end
   end

   task automatic send_sample(input logic [STATION_W-1:0] st,
                              input logic [SAMPLE_W-1:0] smp, input logic pend);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_station    <= st;
      req_sample     <= smp;
      req_packet_end <= pend;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (samples_waiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [GAIN_W-1:0] sg, input logic [GAIN_W-1:0] lg,
                             input logic [GAIN_W-1:0] thr, input logic [GAIN_W-1:0] wl);
      csr_write <= 1'b1;
      csr_index <= CSR_SHORT_GAIN;
      csr_wdata <= sg;
      @(posedge clock);
      csr_index <= CSR_LONG_GAIN;
      csr_wdata <= lg;
      @(posedge clock);
      csr_index <= CSR_RATIO_THRESHOLD;
      csr_wdata <= thr;
      @(posedge clock);
      csr_index <= CSR_WINDOW_LENGTH;
      csr_wdata <= wl;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic random_config();
      logic [GAIN_W-1:0] sg;
      logic [GAIN_W-1:0] lg;
      logic [GAIN_W-1:0] thr;
      sg = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(1500, 30000));
      lg = 16'($urandom_range(1, 2500));
      case ($urandom_range(0, 5))
         0:       thr = '0;
         1:       thr = '1;
         default: thr = 16'($urandom_range(256, 2560));
      endcase
      set_config(sg, lg, thr, 16'($urandom_range(0, 24)));
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(input bit loud);
      logic [SAMPLE_W-1:0] s;
      case ($urandom_range(0, 9))
         0:       s = $urandom();
         1:       s = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         2:       s = '0;
         default: begin
            s = loud ? $urandom_range(0, 32'h00FF_FFFF) : $urandom_range(0, 400);
            if ($urandom_range(0, 1) != 0) begin
               s = -s;
            end
         end
      endcase
      return s;
   endfunction

   // quiet stretches broken by loud bursts, mostly on a few busy stations
   task automatic run_bursts(input int n_items, input int only_station);
      int sent;
      int st;
      int run_len;
      bit loud;
      sent = 0;
      while (sent < n_items) begin
         if (only_station >= 0) begin
            st = only_station;
         end else begin
            st = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
         end
         run_len = $urandom_range(1, 12);
         loud    = ($urandom_range(0, 4) == 0);
         for (int i = 0; i < run_len && sent < n_items; i++) begin
            send_sample(STATION_W'(st), pick_sample(loud), 1'($urandom_range(0, 1)));
            sent++;
         end
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_station    <= '0;
      req_sample     <= '0;
      req_packet_end <= 1'b0;
      csr_write      <= 1'b0;
      csr_index      <= CSR_SHORT_GAIN;
      csr_wdata      <= '0;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      want_hold    = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // defaults after reset: sample extremes on both end stations, patterns on two middle ones
      send_sample(4'd0,  32'h0000_0000, 1'b0);
      send_sample(4'd0,  32'h7FFF_FFFF, 1'b1);
      send_sample(4'd0,  32'h8000_0000, 1'b0);
      send_sample(4'd15, 32'h8000_0000, 1'b1);
      send_sample(4'd15, 32'hFFFF_FFFF, 1'b0);
      send_sample(4'd15, 32'h0000_0001, 1'b1);
      send_sample(4'd7,  32'h5555_5555, 1'b0);
      send_sample(4'd8,  32'hAAAA_AAAA, 1'b1);
      drain();

      // zero window length, full short gain, minimal long gain, top threshold; decay settles above zero
      set_config(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0000);
      send_sample(4'd1, 32'h7FFF_FFFF, 1'b0);
      send_sample(4'd1, 32'h0000_0000, 1'b1);
      send_sample(4'd1, 32'h0000_0000, 1'b0);
      send_sample(4'd4, 32'h0000_0001, 1'b0);
      send_sample(4'd4, 32'h0000_0000, 1'b0);
      send_sample(4'd4, 32'h0000_0000, 1'b1);
      send_sample(4'd2, 32'h8000_0000, 1'b0);
      send_sample(4'd2, 32'h0000_0000, 1'b0);
      drain();

      // zero gains hold the averages; zero threshold; fresh station has zero lta
      set_config(16'h0000, 16'h0000, 16'h0000, 16'h0001);
      send_sample(4'd1, 32'h1234_5678, 1'b0);
      send_sample(4'd2, 32'hFFFF_FFFB, 1'b1);
      send_sample(4'd3, 32'h0000_0064, 1'b0);
      send_sample(4'd3, 32'h8000_0000, 1'b1);
      drain();

      for (int mode = 0; mode < 3; mode++) begin
         req_idle_pct = (mode == 0) ? 31 : (mode == 1) ? 63 : 0;
         rsp_idle_pct = (mode == 0) ? 63 : (mode == 1) ? 31 : 0;
         for (int k = 0; k < 2; k++) begin
            random_config();
            if (mode == 0 && k == 0) begin
               want_hold = 1'b1;
            end
            run_bursts(175, -1);
            drain();
         end
      end

      $display("checked %0d rsp beats, %0d with trigger set", beats_checked, triggers_seen);
      $display("directed extremes and gain corners, then random bursts under three stall mixes");
      if (fail_count == 0 && samples_waiting == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
